// ----- rtl/core/led_color_pixel_pipeline_core_assert.svh -----
// Assertion macros for the LED pixel pipeline core.
// Depends on nothing; included by the top level.
`ifndef LED_COLOR_PIXEL_PIPELINE_CORE_ASSERT_SVH
`define LED_COLOR_PIXEL_PIPELINE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define LCP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define LCP_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define LCP_ASSERT(label, clk, rst_n, prop)
`define LCP_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- rtl/core/lcp_pkg.sv -----
// Package for the LED pixel pipeline: payload types, register indexes, gamma table.
// Used by every module of the core.
`timescale 1ns / 1ps
`default_nettype none
package lcp_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] RegWarmth = 1'd0;
  localparam logic [CfgIdxW-1:0] RegGammaEn = 1'd1;
  localparam logic OpHsv = 1'b0;

  typedef struct packed {
    logic       op;
    logic [15:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_out_t;

  typedef struct packed {
    logic signed [7:0] warmth;
    logic              gamma_en;
  } cfg_t;

  // x / 255 for x < 65280 (exact)
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] y;
    begin
      y = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      div255 = y[15:8];
    end
  endfunction

  function automatic logic [7:0] gamma(input logic [7:0] x);
    logic [7:0] lut [256];
    begin
      lut = '{
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,
        8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
        8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,8'd5,8'd6,8'd6,8'd6,
        8'd6,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,8'd10,8'd11,8'd11,8'd11,8'd12,
        8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,8'd16,8'd16,8'd17,8'd17,8'd18,8'd18,
        8'd19,8'd19,
        8'd20,8'd20,8'd21,8'd22,8'd22,8'd23,8'd23,8'd24,8'd25,8'd25,8'd26,8'd26,8'd27,8'd28,
        8'd28,8'd29,
        8'd30,8'd30,8'd31,8'd32,8'd33,8'd33,8'd34,8'd35,8'd35,8'd36,8'd37,8'd38,8'd39,8'd39,
        8'd40,8'd41,
        8'd42,8'd43,8'd43,8'd44,8'd45,8'd46,8'd47,8'd48,8'd49,8'd49,8'd50,8'd51,8'd52,8'd53,
        8'd54,8'd55,
        8'd56,8'd57,8'd58,8'd59,8'd60,8'd61,8'd62,8'd63,8'd64,8'd65,8'd66,8'd67,8'd68,8'd69,
        8'd70,8'd71,
        8'd73,8'd74,8'd75,8'd76,8'd77,8'd78,8'd79,8'd81,8'd82,8'd83,8'd84,8'd85,8'd87,8'd88,
        8'd89,8'd90,
        8'd91,8'd93,8'd94,8'd95,8'd97,8'd98,8'd99,8'd100,8'd102,8'd103,8'd105,8'd106,8'd107,
        8'd109,8'd110,8'd111,
        8'd113,8'd114,8'd116,8'd117,8'd119,8'd120,8'd121,8'd123,8'd124,8'd126,8'd127,8'd129,
        8'd130,8'd132,8'd133,8'd135,
        8'd137,8'd138,8'd140,8'd141,8'd143,8'd145,8'd146,8'd148,8'd149,8'd151,8'd153,8'd154,
        8'd156,8'd158,8'd159,8'd161,
        8'd163,8'd165,8'd166,8'd168,8'd170,8'd172,8'd173,8'd175,8'd177,8'd179,8'd181,8'd182,
        8'd184,8'd186,8'd188,8'd190,
        8'd192,8'd194,8'd196,8'd197,8'd199,8'd201,8'd203,8'd205,8'd207,8'd209,8'd211,8'd213,
        8'd215,8'd217,8'd219,8'd221,
        8'd223,8'd225,8'd227,8'd229,8'd231,8'd234,8'd236,8'd238,8'd240,8'd242,8'd244,8'd246,
        8'd248,8'd251,8'd253,8'd255};
      gamma = lut[x];
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lcp_hsv.sv -----
// HSV to RGB front end: hue reduction, sector split, p/q/t products (3 stages).
// Depends on lcp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lcp_hsv (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               valid_i,
  input  wire lcp_pkg::pix_in_t pix_i,
  output logic              valid_o,
  output lcp_pkg::pix_out_t pix_o
);

  // stage A: hue mod 360 via quotient estimate (hue*2912>>20 at most 1 low)
  logic [15:0] hue_mod_d;
  logic [27:0] qprod;
  logic [9:0]  qest;
  logic [18:0] rmd;
  always_comb begin
    qprod = {12'd0, pix_i.hue} * 28'd2912;
    qest  = qprod[27:18] >> 2;
    rmd   = {3'd0, pix_i.hue} - {9'd0, qest} * 19'd360;
    if (rmd >= 19'd360) rmd = rmd - 19'd360;
    if (rmd >= 19'd360) rmd = rmd - 19'd360;
    hue_mod_d = rmd[15:0];
  end

  logic             va_q;
  logic [8:0]       ha_q;
  lcp_pkg::pix_in_t pa_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    ha_q <= hue_mod_d[8:0];
    pa_q <= pix_i;
  end

  // stage B: region, rem, s*rem/255, s*(255-rem)/255, v*(255-s)/255
  logic [2:0] region_d;
  logic [5:0] hm60;
  logic [7:0] rem_d;
  logic [7:0] sr_d, srn_d, p_d;
  always_comb begin
    if      (ha_q >= 9'd300) begin region_d = 3'd5; hm60 = 6'(ha_q - 9'd300); end
    else if (ha_q >= 9'd240) begin region_d = 3'd4; hm60 = 6'(ha_q - 9'd240); end
    else if (ha_q >= 9'd180) begin region_d = 3'd3; hm60 = 6'(ha_q - 9'd180); end
    else if (ha_q >= 9'd120) begin region_d = 3'd2; hm60 = 6'(ha_q - 9'd120); end
    else if (ha_q >= 9'd60)  begin region_d = 3'd1; hm60 = 6'(ha_q - 9'd60); end
    else                     begin region_d = 3'd0; hm60 = 6'(ha_q); end
    // rem = hm60*255/60 = hm60*17/4
    rem_d = 8'(({4'd0, hm60} * 10'd17) >> 2);
    sr_d  = lcp_pkg::div255(16'(pa_q.sat) * 16'(rem_d));
    srn_d = lcp_pkg::div255(16'(pa_q.sat) * 16'(8'd255 - rem_d));
    p_d   = lcp_pkg::div255(16'(pa_q.val) * 16'(8'd255 - pa_q.sat));
  end

  logic             vb_q;
  logic [2:0]       rg_q;
  logic [7:0]       sr_q, srn_q, p_q;
  lcp_pkg::pix_in_t pb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end
  always_ff @(posedge clk_i) begin
    rg_q  <= region_d;
    sr_q  <= sr_d;
    srn_q <= srn_d;
    p_q   <= p_d;
    pb_q  <= pa_q;
  end

  // stage C: q, t and sector select
  logic [7:0] q_c, t_c, v_c;
  lcp_pkg::pix_out_t rgb_d;
  always_comb begin
    v_c = pb_q.val;
    q_c = lcp_pkg::div255(16'(v_c) * 16'(8'd255 - sr_q));
    t_c = lcp_pkg::div255(16'(v_c) * 16'(8'd255 - srn_q));
    case (rg_q)
      3'd0:    rgb_d = '{red: v_c, green: t_c, blue: p_q};
      3'd1:    rgb_d = '{red: q_c, green: v_c, blue: p_q};
      3'd2:    rgb_d = '{red: p_q, green: v_c, blue: t_c};
      3'd3:    rgb_d = '{red: p_q, green: q_c, blue: v_c};
      3'd4:    rgb_d = '{red: t_c, green: p_q, blue: v_c};
      default: rgb_d = '{red: v_c, green: p_q, blue: q_c};
    endcase
    if (pb_q.op != lcp_pkg::OpHsv) begin
      rgb_d = '{red: pb_q.red_in, green: pb_q.green_in, blue: pb_q.blue_in};
    end
  end

  logic              vc_q;
  lcp_pkg::pix_out_t rgb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end
  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign valid_o = vc_q;
  assign pix_o   = rgb_q;

endmodule
`default_nettype wire

// ----- rtl/core/lcp_tilt.sv -----
// Warmth tilt and gamma back end (2 stages).
// Depends on lcp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lcp_tilt (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire lcp_pkg::cfg_t cfg_i,
  input  wire               valid_i,
  input  wire lcp_pkg::pix_out_t pix_i,
  output logic              valid_o,
  output lcp_pkg::pix_out_t pix_o
);

  // stage D: ch*pct*warmth product (|x| <= 255*45*100)
  logic signed [7:0] pct_w [3];
  logic signed [21:0] prod_d [3];
  logic [7:0] ch [3];
  always_comb begin
    ch[0] = pix_i.red;
    ch[1] = pix_i.green;
    ch[2] = pix_i.blue;
    pct_w[0] = 8'sd45;
    pct_w[1] = 8'sd12;
    pct_w[2] = -8'sd45;
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = 22'($signed({1'b0, ch[i]})) * 22'(pct_w[i]) * 22'(cfg_i.warmth);
    end
  end

  logic              vd_q;
  logic signed [21:0] prod_q [3];
  logic [7:0]        ch_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    ch_q   <= ch;
  end

  // stage E: truncating /10000 via reciprocal, clamp, gamma
  logic [20:0] mag;
  logic [41:0] qm;
  logic [7:0]  qv;
  logic signed [9:0] x;
  logic [7:0]  c [3];
  lcp_pkg::pix_out_t out_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag = prod_q[i][21] ? 21'(-prod_q[i]) : prod_q[i][20:0];
      // floor(m/10000) = (m*429497)>>32 for m <= 255*45*100
      qm  = {21'd0, mag} * 42'd429497;
      qv  = qm[39:32];
      x   = $signed({2'b0, ch_q[i]})
            + (prod_q[i][21] ? -$signed({2'b0, qv}) : $signed({2'b0, qv}));
      if (x < 0)           c[i] = 8'd0;
      else if (x > 10'sd255) c[i] = 8'd255;
      else                 c[i] = x[7:0];
      if (cfg_i.gamma_en) c[i] = lcp_pkg::gamma(c[i]);
    end
    out_d = '{red: c[0], green: c[1], blue: c[2]};
  end

  logic              ve_q;
  lcp_pkg::pix_out_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else begin
      ve_q <= vd_q;
    end
  end
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = ve_q;
  assign pix_o   = out_q;

endmodule
`default_nettype wire

// ----- rtl/core/led_color_pixel_pipeline_core.sv -----
// LED pixel pipeline top level: config registers, HSV front end, tilt/gamma back end.
// Depends on lcp_pkg, lcp_hsv, lcp_tilt and the assertion header.
//
// Usage: drive start_i with pix_i for one cycle per beat; busy_o is always
// low, so one pixel enters every cycle. Each pixel gives one beat on pix_o
// with done_o high for one cycle, once it has passed the registered stages
// (hue reduce, sector/products, p/q/t select, tilt product, divide/clamp/
// gamma). Throughput is one pixel per cycle. The receiver cannot stall;
// results are presented once. Config is written through cfg_we_i,
// cfg_idx_i and cfg_data_i while the pipe is empty; warmth saturates to
// -100..100 on write. Reset clears warmth, gamma enable and all valid bits.
`timescale 1ns / 1ps
`default_nettype none
`include "led_color_pixel_pipeline_core_assert.svh"
module led_color_pixel_pipeline_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  output logic                               busy_o,
  input  wire lcp_pkg::pix_in_t              pix_i,
  output logic                               done_o,
  output lcp_pkg::pix_out_t                  pix_o,
  input  wire                                cfg_we_i,
  input  wire [lcp_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire [lcp_pkg::CfgDataW-1:0]        cfg_data_i
);

  lcp_pkg::cfg_t cfg_q, cfg_d;
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lcp_pkg::RegWarmth: begin
          if ($signed(cfg_data_i) > 8'sd100)       cfg_d.warmth = 8'sd100;
          else if ($signed(cfg_data_i) < -8'sd100) cfg_d.warmth = -8'sd100;
          else                                     cfg_d.warmth = $signed(cfg_data_i);
        end
        lcp_pkg::RegGammaEn: cfg_d.gamma_en = cfg_data_i[0];
        default: ;
      endcase
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign busy_o = 1'b0;

  logic              mid_v;
  lcp_pkg::pix_out_t mid_pix;

  lcp_hsv u_hsv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .pix_i   (pix_i),
    .valid_o (mid_v),
    .pix_o   (mid_pix)
  );

  lcp_tilt u_tilt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (mid_v),
    .pix_i   (mid_pix),
    .valid_o (done_o),
    .pix_o   (pix_o)
  );

  `LCP_ASSERT(a_latency, clk_i, rst_ni, start_i |-> ##5 done_o)
  `LCP_ASSERT(a_no_spurious, clk_i, rst_ni, done_o |-> $past(start_i, 5))
  `LCP_ASSERT(a_warmth_range, clk_i, rst_ni, cfg_q.warmth <= 8'sd100 && cfg_q.warmth >= -8'sd100)

endmodule
`default_nettype wire
